/* sv/tkd_pkg.sv */
package tkd_pkg;

  // Width of the configuration address: two 32-bit registers at byte offsets 0 and 4.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // Register indexes, taken from the word address bit.
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  // Register reset values.
  localparam logic [15:0] DEBOUNCE_RESET   = 16'd30;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

  // Per-key debounce phase, one-hot.
  typedef enum logic [3:0] {
    PH_RELEASED   = 4'b0001,
    PH_PRESS_DB   = 4'b0010,
    PH_PRESSED    = 4'b0100,
    PH_RELEASE_DB = 4'b1000
  } key_phase_t;

  // One scan request.
  typedef struct packed {
    logic        key1_level;
    logic        key2_level;
    logic [31:0] now_ms;
  } in_t;

  // One result.
  typedef struct packed {
    logic key2_press_event;
    logic key1_release_event;
    logic chord_event;
    logic key1_long_event;
    logic key2_long_event;
    logic key1_held;
    logic key2_held;
  } out_t;

  // What one key lane found during the current scan.
  typedef struct packed {
    logic press;
    logic release_ev;
    logic long_ev;
    logic held_prev;
    logic held_new;
  } lane_res_t;

endpackage

/* sv/tkd_lane.sv */
module tkd_lane (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             level,
  input  logic [31:0]      now_ms,
  input  logic [15:0]      debounce_ms,
  input  logic [15:0]      long_press_ms,
  output tkd_pkg::lane_res_t res
);
  import tkd_pkg::*;

  key_phase_t  phase_r, phase_nxt;
  logic [31:0] mark_r, mark_nxt;
  logic        held_r, held_nxt;
  logic [31:0] elapsed;
  logic        db_over;
  logic        lp_over;

  // Elapsed time wraps modulo 2^32; both thresholds are strict.
  assign elapsed = now_ms - mark_r;
  assign db_over = elapsed > {16'd0, debounce_ms};
  assign lp_over = elapsed > {16'd0, long_press_ms};

  // Debounce and long-press machine for one key.
  always_comb begin
    phase_nxt      = phase_r;
    mark_nxt       = mark_r;
    held_nxt       = held_r;
    res.press      = 1'b0;
    res.release_ev = 1'b0;
    res.long_ev    = 1'b0;
    unique case (phase_r)
      PH_RELEASED: begin
        if (level) begin
          phase_nxt = PH_PRESS_DB;
          mark_nxt  = now_ms;
        end
      end
      PH_PRESS_DB: begin
        if (db_over) begin
          if (level) begin
            phase_nxt = PH_PRESSED;
            held_nxt  = 1'b1;
            res.press = 1'b1;
          end else begin
            phase_nxt = PH_RELEASED;
          end
        end
      end
      PH_PRESSED: begin
        if (!level) begin
          phase_nxt = PH_RELEASE_DB;
          mark_nxt  = now_ms;
        end else if (lp_over) begin
          res.long_ev = 1'b1;
          mark_nxt    = now_ms;
        end
      end
      PH_RELEASE_DB: begin
        if (db_over) begin
          if (!level) begin
            phase_nxt      = PH_RELEASED;
            held_nxt       = 1'b0;
            res.release_ev = 1'b1;
          end else begin
            phase_nxt = PH_PRESSED;
          end
        end
      end
      default: begin
        phase_nxt = PH_RELEASED;
      end
    endcase
    res.held_prev = held_r;
    res.held_new  = held_nxt;
  end

  // State advances only when a scan request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASED;
      mark_r  <= '0;
      held_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      mark_r  <= mark_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

/* sv/tkd_merge.sv */
module tkd_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tkd_pkg::lane_res_t key1_res,
  input  tkd_pkg::lane_res_t key2_res,
  output logic               out_valid,
  input  logic               out_stall,
  output tkd_pkg::out_t      out_data
);
  import tkd_pkg::*;

  out_t merged;
  out_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;
  logic in_acc, out_take;

  // Key one is scanned first, so its chord check sees key two's old flag,
  // while key two's check sees key one's flag after this scan.
  always_comb begin
    merged.key2_press_event   = key2_res.press;
    merged.key1_release_event = key1_res.release_ev;
    merged.chord_event        = (key1_res.press && key2_res.held_prev) ||
                                (key2_res.press && key1_res.held_new);
    merged.key1_long_event    = key1_res.long_ev;
    merged.key2_long_event    = key2_res.long_ev;
    merged.key1_held          = key1_res.held_new;
    merged.key2_held          = key2_res.held_new;
  end

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_r       <= merged;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= merged;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

/* sv/two_key_debounce_event_detector.sv */
// Two-key debounce and event detector.
// Each result is registered in the output register, or in the skid stage while a result waits there.
// Throughput: one scan request per cycle while in_stall is low; the two key lanes update in parallel.
// A skid stage lets one more request in while a result waits at the output.
// Synchronous active-low reset: both keys released, marks and flags cleared,
// registers back to 30 ms debounce and 1000 ms long press, output empty.
module two_key_debounce_event_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tkd_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tkd_pkg::out_t                   out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tkd_pkg::CfgAddrW-1:0]    paddr,
  input  logic [tkd_pkg::CfgDataW-1:0]    pwdata,
  output logic [tkd_pkg::CfgDataW-1:0]    prdata,
  output logic                            pready
);
  import tkd_pkg::*;

  logic [15:0] debounce_r;
  logic [15:0] long_press_r;
  logic        cfg_wr;
  logic        accept;
  lane_res_t   key1_res, key2_res;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DEBOUNCE:   debounce_r   <= pwdata[15:0];
        REG_LONG_PRESS: long_press_r <= pwdata[15:0];
        default:        debounce_r   <= debounce_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE:   prdata = {16'd0, debounce_r};
      REG_LONG_PRESS: prdata = {16'd0, long_press_r};
      default:        prdata = '0;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // One lane per key.
  tkd_lane u_key1 (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .level        (in_data.key1_level),
    .now_ms       (in_data.now_ms),
    .debounce_ms  (debounce_r),
    .long_press_ms(long_press_r),
    .res          (key1_res)
  );

  tkd_lane u_key2 (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .level        (in_data.key2_level),
    .now_ms       (in_data.now_ms),
    .debounce_ms  (debounce_r),
    .long_press_ms(long_press_r),
    .res          (key2_res)
  );

  // Merge the lane findings and register the result.
  tkd_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .key1_res (key1_res),
    .key2_res (key2_res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

/* sv/tkd_checker.sv */
module tkd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input tkd_pkg::out_t out_data
);

  // No result is left over after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A confirmed key-two press leaves key two held.
  a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.key2_press_event |-> out_data.key2_held)
    else $error("key two press without held flag");

  // A confirmed key-one release leaves key one released.
  a_release_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.key1_release_event |-> !out_data.key1_held)
    else $error("key one release with held flag set");

  // Either confirmation behind a chord leaves key one held, so a chord never
  // comes with a key-one release. Key two may still confirm a release in the
  // same scan when key one's press made the chord.
  a_chord_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chord_event |->
      out_data.key1_held && !out_data.key1_release_event)
    else $error("chord without key one held");

endmodule

bind two_key_debounce_event_detector tkd_checker u_tkd_checker (.*);

/* tb/two_key_debounce_event_detector_tb.sv */
module two_key_debounce_event_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tkd_pkg::*;

  localparam int ClkPeriod = 8;
  localparam int IdleLimit = 2000;
  localparam int NumSettings = 7;
  localparam int ScansPerSetting = 85;

  // Clock, reset and every block input start at known values.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  two_key_debounce_event_detector i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Debounce state kept alongside the block, one entry per key.
  key_phase_t key_state [2];
  logic [31:0] key_mark [2];
  logic key_held [2];
  logic [15:0] debounce_ms;
  logic [15:0] long_press_ms;

  out_t events_due [$];
  int mismatches = 0;
  int results_seen = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_mode = 0;

  // One directed scan: the request and, where obvious, its result.
  typedef struct {
    in_t req;
    bit typed;
    out_t want;
  } scan_row_t;

  // Result bits run: key2 press, key1 release, chord, key1 long, key2 long,
  // key1 held, key2 held.
  scan_row_t directed_rows [24] = '{
    // Idle keys straight after reset, then both pressed.
    '{'{1'b0, 1'b0, 32'h0000_0000}, 1'b1, 7'b0000000},
    '{'{1'b1, 1'b1, 32'h0000_0000}, 1'b1, 7'b0000000},
    // Exactly the debounce time is not enough; one more confirms both.
    '{'{1'b1, 1'b1, 32'd30}, 1'b0, '0},
    '{'{1'b1, 1'b1, 32'd31}, 1'b1, 7'b1010011},
    // Key one bounces during release and goes back to pressed.
    '{'{1'b0, 1'b1, 32'd100}, 1'b0, '0},
    '{'{1'b1, 1'b1, 32'd131}, 1'b0, '0},
    '{'{1'b1, 1'b1, 32'd1101}, 1'b0, '0},
    // Both released together.
    '{'{1'b0, 1'b0, 32'd1200}, 1'b0, '0},
    '{'{1'b0, 1'b0, 32'd1231}, 1'b1, 7'b0100000},
    // Press that fails its debounce across the timestamp wrap.
    '{'{1'b1, 1'b0, 32'hFFFF_FFF0}, 1'b0, '0},
    '{'{1'b0, 1'b0, 32'h0000_000F}, 1'b0, '0},
    // Press confirmed across the wrap.
    '{'{1'b1, 1'b0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{1'b1, 1'b0, 32'h0000_001F}, 1'b0, '0},
    // Timestamp jumps backwards: long press on key one, chord from key two.
    '{'{1'b1, 1'b1, 32'h0000_0020}, 1'b0, '0},
    '{'{1'b1, 1'b1, 32'hFFFF_0000}, 1'b1, 7'b1011011},
    '{'{1'b0, 1'b0, 32'h8000_0000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 32'h8000_001F}, 1'b0, '0},
    // Key two held first, then a chord from key one's confirmation.
    '{'{1'b0, 1'b1, 32'h8000_0100}, 1'b0, '0},
    '{'{1'b0, 1'b1, 32'h8000_0200}, 1'b0, '0},
    '{'{1'b1, 1'b1, 32'h8000_0210}, 1'b0, '0},
    '{'{1'b1, 1'b1, 32'h8000_0230}, 1'b0, '0},
    // Key two fails its release debounce, then both reach a long press.
    '{'{1'b1, 1'b0, 32'h8000_0240}, 1'b0, '0},
    '{'{1'b1, 1'b1, 32'h8000_0260}, 1'b0, '0},
    '{'{1'b1, 1'b1, 32'h8000_0640}, 1'b0, '0}
  };

  // Register settings per random stretch; the fifth is drawn at run time.
  logic [15:0] debounce_set [NumSettings] = '{16'd30, 16'd0, 16'hFFFF, 16'd1, 16'd0,
                                              16'hFFFF, 16'd0};
  logic [15:0] long_press_set [NumSettings] = '{16'd1000, 16'd0, 16'hFFFF, 16'd3, 16'd0,
                                                16'd0, 16'hFFFF};

  // Advances one key by one scan and reports what it confirmed.
  function automatic void advance_key(int k, logic level, logic [31:0] now,
                                      output logic press, output logic rel,
                                      output logic long_hit);
    logic [31:0] elapsed;
    elapsed = now - key_mark[k];
    press = 1'b0;
    rel = 1'b0;
    long_hit = 1'b0;
    case (key_state[k])
      PH_RELEASED: begin
        if (level) begin
          key_state[k] = PH_PRESS_DB;
          key_mark[k] = now;
        end
      end
      PH_PRESS_DB: begin
        if (elapsed > debounce_ms) begin
          if (level) begin
            key_state[k] = PH_PRESSED;
            key_held[k] = 1'b1;
            press = 1'b1;
          end else begin
            key_state[k] = PH_RELEASED;
          end
        end
      end
      PH_PRESSED: begin
        if (!level) begin
          key_state[k] = PH_RELEASE_DB;
          key_mark[k] = now;
        end else if (elapsed > long_press_ms) begin
          long_hit = 1'b1;
          key_mark[k] = now;
        end
      end
      default: begin
        if (elapsed > debounce_ms) begin
          if (!level) begin
            key_state[k] = PH_RELEASED;
            key_held[k] = 1'b0;
            rel = 1'b1;
          end else begin
            key_state[k] = PH_PRESSED;
          end
        end
      end
    endcase
  endfunction

  // Works out the events of one scan; key one is updated before key two.
  function automatic out_t debounce_scan(in_t scan);
    out_t res;
    logic p1, r1, l1, p2, r2, l2;
    res = '0;
    advance_key(0, scan.key1_level, scan.now_ms, p1, r1, l1);
    if (p1 && key_held[0] && key_held[1]) res.chord_event = 1'b1;
    advance_key(1, scan.key2_level, scan.now_ms, p2, r2, l2);
    if (p2 && key_held[0] && key_held[1]) res.chord_event = 1'b1;
    res.key2_press_event = p2;
    res.key1_release_event = r1;
    res.key1_long_event = l1;
    res.key2_long_event = l2;
    res.key1_held = key_held[0];
    res.key2_held = key_held[1];
    return res;
  endfunction

  function automatic void flag_error(string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endfunction

  // Offers one scan request in bursts with random gaps, then records its events.
  task automatic send_scan(in_t req, bit typed, out_t want);
    out_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    predicted = debounce_scan(req);
    events_due.push_back(typed ? want : predicted);
  endtask

  // Holds the sender back until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (events_due.size() != 0);
  endtask

  // Setup and access cycle, then an idle wait with psel low so that writes never overlap.
  task automatic write_reg(logic idx, logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_DEBOUNCE) debounce_ms = val;
    else long_press_ms = val;
    @(posedge clk);
  endtask

  // The receiver stalls on patterns of its own: none, sparse, toggling, solid.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 6) : $urandom_range(4, 30);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ~out_stall;
      default: out_stall <= 1'b1;
    endcase
  end

  // Each taken result is compared against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (events_due.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing outstanding: %p",
                             results_seen, out_data));
      end else begin
        out_t want;
        want = events_due.pop_front();
        if (out_data !== want)
          flag_error($sformatf("result %0d: expected %p, got %p",
                               results_seen, want, out_data));
      end
      results_seen++;
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_t req;
    logic [31:0] clock_ms;
    logic aim1, aim2;
    int unsigned step;

    key_state = '{PH_RELEASED, PH_RELEASED};
    key_mark = '{32'd0, 32'd0};
    key_held = '{1'b0, 1'b0};
    debounce_ms = DEBOUNCE_RESET;
    long_press_ms = LONG_PRESS_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_scan(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    drain();

    debounce_set[4] = 16'($urandom_range(2, 200));
    long_press_set[4] = 16'($urandom_range(5, 3000));
    clock_ms = $urandom;
    aim1 = 1'b0;
    aim2 = 1'b0;

    // Random stretches, each under its own register setting.
    for (int s = 0; s < NumSettings; s++) begin
      if (s > 0) begin
        write_reg(REG_DEBOUNCE, debounce_set[s]);
        write_reg(REG_LONG_PRESS, long_press_set[s]);
      end
      for (int n = 0; n < ScansPerSetting; n++) begin
        if (n == ScansPerSetting / 2) drain();
        if ($urandom_range(0, 19) == 0) begin
          // Noise: a scan with no relation to the key history.
          req.key1_level = 1'($urandom);
          req.key2_level = 1'($urandom);
          req.now_ms = $urandom;
        end else begin
          if ($urandom_range(0, 29) == 0) clock_ms = $urandom;
          case ($urandom_range(0, 7))
            0, 1, 2, 3: step = $urandom_range(0, debounce_ms / 2 + 1);
            4, 5: step = debounce_ms + $urandom_range(0, 2);
            6: step = long_press_ms + $urandom_range(0, 2);
            default: step = $urandom_range(0, long_press_ms / 4 + 1);
          endcase
          clock_ms = clock_ms + step;
          if ($urandom_range(0, 5) == 0) aim1 = ~aim1;
          if ($urandom_range(0, 5) == 0) aim2 = ~aim2;
          // Occasional contact bounce flips the sampled level.
          req.key1_level = aim1 ^ ($urandom_range(0, 9) == 0);
          req.key2_level = aim2 ^ ($urandom_range(0, 9) == 0);
          req.now_ms = clock_ms;
        end
        send_scan(req, 1'b0, '0);
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* two_key_debounce_event_detector.f */
sv/tkd_pkg.sv
sv/tkd_lane.sv
sv/tkd_merge.sv
sv/two_key_debounce_event_detector.sv
sv/tkd_checker.sv
tb/two_key_debounce_event_detector_tb.sv
